### hw/rtl/aes_ctr_pkg.sv
// Shared types, constants and AES helper functions for the AES-128 CTR block.
package aes_ctr_pkg;

  localparam int unsigned NonceBytesDefault = 8;
  localparam int unsigned FifoDepthDefault  = 2;
  localparam int unsigned NumRounds         = 10;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_NONCE    = 2'd2
  } cfg_idx_e;

  // One job handed from the front end to the cipher engine.
  typedef struct packed {
    logic [127:0] ctr_blk;
    logic [127:0] data;
    logic         eom;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block sits at bits 127-8i .. 120-8i.
  function automatic logic [7:0] byte_of(input logic [127:0] s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
    logic [7:0] sb [16];
    logic [7:0] sr [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) sb[i] = sbox(byte_of(s, i));
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++) sr[w + 4*c] = sb[w + 4*((c + w) % 4)];
    for (int c = 0; c < 4; c++) begin
      a0 = sr[4*c]; a1 = sr[4*c+1]; a2 = sr[4*c+2]; a3 = sr[4*c+3];
      if (!last) begin
        sr[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        sr[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        sr[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        sr[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = sr[i];
    return r ^ rk;
  endfunction

  function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

### hw/rtl/aes_ctr_front.sv
// Front end: counts blocks, builds counter blocks and queues jobs for the engine.
module aes_ctr_front import aes_ctr_pkg::*; #(
  parameter int unsigned NonceBytes = NonceBytesDefault,
  parameter int unsigned FifoDepth  = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_high_i,
  input  logic [63:0] data_low_i,
  input  logic        start_of_message_i,
  input  logic        end_of_message_i,
  input  logic [63:0] nonce_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);
  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic [63:0] blk_cnt_q, blk_cnt_d, cnt_use;
  logic [127:0] ctr_blk;
  job_t        mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic push, pop;

  assign cnt_use = start_of_message_i ? 64'd0 : blk_cnt_q;

  // Byte selects are masked to 0..7 so the unused arm never indexes out of range.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (i < NonceBytes) ctr_blk[127-8*i -: 8] = (i < 8) ? nonce_i[63-8*(i & 7) -: 8] : 8'h00;
      else ctr_blk[127-8*i -: 8] = ((15 - i) < 8) ? cnt_use[8*((15-i) & 7) +: 8] : 8'h00;
    end
  end

  assign in_ready    = (cnt_q != CntW'(FifoDepth));
  assign push        = in_valid && in_ready;
  assign job_valid_o = (cnt_q != '0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = mem_q[rd_q];
  assign blk_cnt_d   = cnt_use + 64'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_cnt_q <= '0;
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        blk_cnt_q <= blk_cnt_d;
        wr_q <= (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) rd_q <= (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= '{ctr_blk: ctr_blk, data: {data_high_i, data_low_i},
                                eom: end_of_message_i};
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth)) else $error("queue count overflow");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == CntW'($past(cnt_q) + 1'b1)) else $error("push lost");
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push && pop |=> cnt_q == CntW'($past(cnt_q) - 1'b1)) else $error("pop lost");
endmodule

### hw/rtl/aes_ctr_engine.sv
// Back end: iterative AES-128 with on-the-fly key schedule and output register.
module aes_ctr_engine import aes_ctr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [127:0] key_i,
  input  logic         job_valid_i,
  output logic         job_ready_o,
  input  job_t         job_i,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  out_high_o,
  output logic [63:0]  out_low_o,
  output logic         end_of_message_out_o
);
  logic         busy_q;
  logic [3:0]   rnd_q;
  logic [127:0] st_q, rk_q, data_q, rk_nx, st_nx;
  logic [7:0]   rc_q;
  logic         eom_q;
  logic         ov_q;
  logic         finish;

  assign rk_nx  = next_rkey(rk_q, rc_q);
  assign st_nx  = aes_round(st_q, rk_nx, rnd_q == 4'(NumRounds));
  assign finish = busy_q && (rnd_q == 4'(NumRounds)) && (!ov_q || out_ready);
  assign job_ready_o = !busy_q;
  assign out_valid = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (finish) ov_q <= 1'b1;
      else if (ov_q && out_ready) ov_q <= 1'b0;
      if (!busy_q && job_valid_i) begin
        busy_q <= 1'b1;
        rnd_q  <= 4'd1;
      end else if (busy_q && rnd_q != 4'(NumRounds)) begin
        rnd_q <= rnd_q + 4'd1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && job_valid_i) begin
      st_q   <= job_i.ctr_blk ^ key_i;
      rk_q   <= key_i;
      rc_q   <= 8'h01;
      data_q <= job_i.data;
      eom_q  <= job_i.eom;
    end else if (busy_q && rnd_q != 4'(NumRounds)) begin
      st_q <= st_nx;
      rk_q <= rk_nx;
      rc_q <= xtime(rc_q);
    end
    if (finish) begin
      {out_high_o, out_low_o} <= st_nx ^ data_q;
      end_of_message_out_o <= eom_q;
    end
  end

  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rnd_q >= 4'd1 && rnd_q <= 4'(NumRounds)))
    else $error("round counter out of range");
  a_finish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> ov_q) else $error("finished block not presented");
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready |=> ov_q && $stable(out_high_o) && $stable(out_low_o))
    else $error("output overwritten");
endmodule

### hw/rtl/aes128_ctr_keystream_xor.sv
// Top level of the AES-128 counter-mode keystream XOR block.
// Usage:
//  - Configuration: cfg_valid/cfg_ready with cfg_index_i (0 key_high, 1 key_low,
//    2 nonce_value) and cfg_data_i; cfg_ready is always high. Other indexes
//    are ignored. Write only while idle.
//  - Input items: in_valid/in_ready carry one 16-byte block plus
//    start_of_message (clears the block counter first) and end_of_message.
//  - Result items: out_valid/out_ready carry the XORed block and the marker.
//  - The engine takes a new item only once the last one is done: a single round
//    unit runs the initial key add plus ten rounds, key schedule computed alongside.
//  - A FifoDepth-entry queue (two by default) sits between the front end and the engine; the result
//    register lets the engine finish its rounds while the receiver stalls,
//    then holds the last round until out_ready.
//  - Reset clears keys, nonce, block counter, queue and all valid flags.
module aes128_ctr_keystream_xor import aes_ctr_pkg::*; #(
  parameter int unsigned NonceBytes = NonceBytesDefault,
  parameter int unsigned FifoDepth  = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_high_i,
  input  logic [63:0] data_low_i,
  input  logic        start_of_message_i,
  input  logic        end_of_message_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_high_o,
  output logic [63:0] out_low_o,
  output logic        end_of_message_out_o
);
  logic [63:0] key_high_q, key_low_q, nonce_q;
  logic job_valid, job_ready;
  job_t job;

  assign cfg_ready = 1'b1;

  // Config registers: index compare on the full word so stray indexes do nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      nonce_q    <= '0;
    end else if (cfg_valid) begin
      if (cfg_index_i == 64'(CFG_KEY_HIGH)) key_high_q <= cfg_data_i;
      if (cfg_index_i == 64'(CFG_KEY_LOW))  key_low_q  <= cfg_data_i;
      if (cfg_index_i == 64'(CFG_NONCE))    nonce_q    <= cfg_data_i;
    end
  end

  aes_ctr_front #(.NonceBytes(NonceBytes), .FifoDepth(FifoDepth)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .data_high_i, .data_low_i,
    .start_of_message_i, .end_of_message_i, .nonce_i(nonce_q),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  aes_ctr_engine u_engine (
    .clk_i, .rst_ni, .key_i({key_high_q, key_low_q}),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .out_valid, .out_ready, .out_high_o, .out_low_o, .end_of_message_out_o
  );
endmodule
